/* src/cdeh_pkg.sv */
package cdeh_pkg;

  localparam int ENTRIES = 1024;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = AW + 1;
  localparam int KEY_W   = 32;

  localparam logic [KEY_W-1:0] ODD_LIMIT = 32'hFFFFFFFF / 32'd3 - 32'd1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_MIN  = 2'd1;
  localparam logic [1:0] MODE_MAX  = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADNO = 2'd3;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [AW-1:0]    idx_t;

  // true if entry ea with key ka belongs above entry eb with key kb
  function automatic logic ahead(input logic is_max, input key_t ka, input idx_t ea,
                                 input key_t kb, input idx_t eb);
    logic res;
    if (ka == kb) res = (ea < eb);
    else if (is_max) res = (ka > kb);
    else res = (ka < kb);
    return res;
  endfunction

  function automatic key_t collatz(input key_t n);
    key_t res;
    if (!n[0]) res = n >> 1;
    else if (n > ODD_LIMIT) res = '0;
    else res = n + (n << 1) + key_t'(1);
    return res;
  endfunction

endpackage

/* src/collatz_double_ended_heap_core.sv */
// load: stores the key, then two sift-up passes, first in the max heap, then in the min heap
// step: a min step first drops keys below 2, then sift up and down in both heaps
// read: one item in flight, each memory has one read and one write port
// the output register lets the next transaction start while a result waits
// reset clears counts and control only; the memories are not cleared
module collatz_double_ended_heap_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // load_value[31:0], read_entry[42:32], zero pad
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // entry[10:0], key[42:11], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);
  import cdeh_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_L0  = 5'd1,  S_L1  = 5'd2,  S_L2  = 5'd3,
                         S_L3   = 5'd4,  S_L4  = 5'd5,  S_SU0 = 5'd6,  S_SU1 = 5'd7,
                         S_SU2  = 5'd8,  S_SU3 = 5'd9,  S_SU4 = 5'd10, S_SU5 = 5'd11,
                         S_SD0  = 5'd12, S_SD1 = 5'd13, S_SD2 = 5'd14, S_SD3 = 5'd15,
                         S_SD4  = 5'd16, S_SD5 = 5'd17, S_SD6 = 5'd18, S_SDC = 5'd19,
                         S_SD8  = 5'd20, S_S0  = 5'd21, S_S1  = 5'd22, S_S2  = 5'd23,
                         S_S3   = 5'd24, S_S4  = 5'd25, S_X1  = 5'd26, S_X2  = 5'd27,
                         S_E0   = 5'd28, S_E1  = 5'd29, S_E2  = 5'd30, S_E3  = 5'd31;
  // E4, E5, read and finish use a second code space
  logic [5:0] state_r;
  localparam logic [5:0] Q_E4 = 6'd32, Q_E5 = 6'd33, Q_R1 = 6'd34, Q_FIN = 6'd35;

  logic [5:0]  ret_r;
  logic        down_r, h_r;
  logic [CW-1:0] lc_r, mhc_r, cnt_r;
  idx_t        p_r, a_r, b_r, e_r, best_r, beste_r;
  key_t        ak_r, bestk_r, ek_r, v_r;
  logic [CW-1:0] res_entry_r, out_entry_r;
  key_t        res_key_r, out_key_r;
  logic [1:0]  res_status_r, out_status_r;
  logic        out_valid_r;

  // memory ports
  logic ks_we, sl_we, ps_we;
  idx_t ks_waddr, ks_raddr, sl_waddr, sl_raddr, ps_waddr, ps_raddr;
  key_t ks_wdata, ks_rd;
  idx_t sl_wdata, ps_wdata, sl_rd, ps_rd;
  idx_t mns_rd, mxs_rd, mnp_rd, mxp_rd;

  idx_t par;
  logic [CW:0] lft, rgt;
  assign par = (p_r - idx_t'(1)) >> 1;
  assign lft = {1'b0, p_r, 1'b1};
  assign rgt = (CW+1)'({p_r, 1'b0}) + (CW+1)'(2);

  assign sl_rd = h_r ? mxs_rd : mns_rd;
  assign ps_rd = h_r ? mxp_rd : mnp_rd;

  cdeh_ram #(.W(KEY_W), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata), .raddr(ks_raddr),
    .rdata(ks_rd));
  cdeh_ram #(.W(AW), .DEPTH(ENTRIES)) u_min_slots (
    .clk(clk), .we(sl_we & ~h_r), .waddr(sl_waddr), .wdata(sl_wdata), .raddr(sl_raddr),
    .rdata(mns_rd));
  cdeh_ram #(.W(AW), .DEPTH(ENTRIES)) u_max_slots (
    .clk(clk), .we(sl_we & h_r), .waddr(sl_waddr), .wdata(sl_wdata), .raddr(sl_raddr),
    .rdata(mxs_rd));
  cdeh_ram #(.W(AW), .DEPTH(ENTRIES)) u_min_pos (
    .clk(clk), .we(ps_we & ~h_r), .waddr(ps_waddr), .wdata(ps_wdata), .raddr(ps_raddr),
    .rdata(mnp_rd));
  cdeh_ram #(.W(AW), .DEPTH(ENTRIES)) u_max_pos (
    .clk(clk), .we(ps_we & h_r), .waddr(ps_waddr), .wdata(ps_wdata), .raddr(ps_raddr),
    .rdata(mxp_rd));

  always_comb begin
    ks_we = 1'b0; ks_waddr = '0; ks_wdata = '0; ks_raddr = '0;
    sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_raddr = '0;
    ps_we = 1'b0; ps_waddr = '0; ps_wdata = '0; ps_raddr = '0;
    case (state_r)
      {1'b0, S_L0}: begin
        ks_we = 1'b1; ks_waddr = e_r; ks_wdata = v_r;
        sl_we = 1'b1; sl_waddr = e_r; sl_wdata = e_r;
        ps_we = 1'b1; ps_waddr = e_r; ps_wdata = e_r;
        // entry that sits just past the min heap end
        sl_raddr = mhc_r[AW-1:0];
      end
      {1'b0, S_L1}: begin
        sl_we = 1'b1; sl_waddr = e_r; sl_wdata = sl_rd;
        ps_we = 1'b1; ps_waddr = sl_rd; ps_wdata = e_r;
      end
      {1'b0, S_L2}: begin
        sl_we = 1'b1; sl_waddr = mhc_r[AW-1:0]; sl_wdata = e_r;
        ps_we = 1'b1; ps_waddr = e_r; ps_wdata = mhc_r[AW-1:0];
      end
      {1'b0, S_SU0}: sl_raddr = p_r;
      {1'b0, S_SU1}: sl_raddr = par;
      {1'b0, S_SU2}: ks_raddr = a_r;
      {1'b0, S_SU3}: ks_raddr = b_r;
      {1'b0, S_SU4}: begin
        if (ahead(h_r, ak_r, a_r, ks_rd, b_r)) begin
          sl_we = 1'b1; sl_waddr = p_r; sl_wdata = b_r;
          ps_we = 1'b1; ps_waddr = a_r; ps_wdata = par;
        end
      end
      {1'b0, S_SU5}: begin
        sl_we = 1'b1; sl_waddr = par; sl_wdata = a_r;
        ps_we = 1'b1; ps_waddr = b_r; ps_wdata = p_r;
      end
      {1'b0, S_SD0}: sl_raddr = p_r;
      {1'b0, S_SD1}: ks_raddr = sl_rd;
      {1'b0, S_SD2}: sl_raddr = lft[AW-1:0];
      {1'b0, S_SD3}: ks_raddr = sl_rd;
      {1'b0, S_SD4}: sl_raddr = rgt[AW-1:0];
      {1'b0, S_SD5}: ks_raddr = sl_rd;
      {1'b0, S_SDC}: begin
        if (best_r != p_r) begin
          sl_we = 1'b1; sl_waddr = p_r; sl_wdata = beste_r;
          ps_we = 1'b1; ps_waddr = a_r; ps_wdata = best_r;
        end
      end
      {1'b0, S_SD8}: begin
        sl_we = 1'b1; sl_waddr = best_r; sl_wdata = a_r;
        ps_we = 1'b1; ps_waddr = beste_r; ps_wdata = p_r;
      end
      {1'b0, S_S0}: sl_raddr = '0;
      {1'b0, S_S1}: ks_raddr = sl_rd;
      {1'b0, S_S2}: sl_raddr = idx_t'(mhc_r - CW'(1));
      {1'b0, S_S3}: begin
        sl_we = 1'b1; sl_waddr = '0; sl_wdata = sl_rd;
        ps_we = 1'b1; ps_waddr = a_r; ps_wdata = mhc_r[AW-1:0];
      end
      {1'b0, S_S4}: begin
        sl_we = 1'b1; sl_waddr = mhc_r[AW-1:0]; sl_wdata = a_r;
        ps_we = 1'b1; ps_waddr = b_r; ps_wdata = '0;
      end
      {1'b0, S_X1}: ks_raddr = sl_rd;
      {1'b0, S_E0}: ks_raddr = e_r;
      {1'b0, S_E1}: begin
        ks_we = 1'b1; ks_waddr = e_r; ks_wdata = collatz(ks_rd);
        ps_raddr = e_r;
      end
      {1'b0, S_E3}: ps_raddr = e_r;
      default: begin
        if (state_r == {1'b0, S_IDLE}) begin
          ks_raddr = idx_t'(in_tdata[42:32] - 11'd1);
          sl_raddr = '0;
        end
      end
    endcase
  end

  assign in_tready = (state_r == {1'b0, S_IDLE});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= {1'b0, S_IDLE};
      lc_r        <= '0;
      mhc_r       <= '0;
      out_valid_r <= 1'b0;
      h_r         <= 1'b0;
      down_r      <= 1'b0;
      ret_r       <= {1'b0, S_IDLE};
    end else begin
      if (out_valid_r && out_tready && state_r != Q_FIN) out_valid_r <= 1'b0;
      case (state_r)
        {1'b0, S_IDLE}: begin
          if (in_tvalid) begin
            v_r    <= in_tdata[31:0];
            e_r    <= lc_r[AW-1:0];
            res_entry_r <= '0; res_key_r <= '0;
            case (in_tuser)
              MODE_LOAD: begin
                h_r <= 1'b1;
                if (lc_r == CW'(ENTRIES)) begin
                  res_status_r <= ST_FULL; state_r <= Q_FIN;
                end else begin
                  state_r <= {1'b0, S_L0};
                end
              end
              MODE_MIN: begin
                h_r <= 1'b0; state_r <= {1'b0, S_S0};
              end
              MODE_MAX: begin
                h_r <= 1'b1;
                if (lc_r == '0) begin
                  res_status_r <= ST_NONE; state_r <= Q_FIN;
                end else begin
                  state_r <= {1'b0, S_X1};
                end
              end
              default: begin
                if (in_tdata[42:32] == '0 || in_tdata[42:32] > lc_r) begin
                  res_status_r <= ST_BADNO; state_r <= Q_FIN;
                end else begin
                  res_entry_r <= in_tdata[42:32]; state_r <= Q_R1;
                end
              end
            endcase
          end
        end
        {1'b0, S_L0}: begin
          h_r <= 1'b0;
          state_r <= (mhc_r < lc_r) ? {1'b0, S_L1} : {1'b0, S_L2};
        end
        {1'b0, S_L1}: state_r <= {1'b0, S_L2};
        {1'b0, S_L2}: begin
          lc_r <= lc_r + CW'(1); mhc_r <= mhc_r + CW'(1);
          h_r <= 1'b1; p_r <= e_r; down_r <= 1'b0; ret_r <= {1'b0, S_L3};
          state_r <= {1'b0, S_SU0};
        end
        {1'b0, S_L3}: begin
          h_r <= 1'b0; p_r <= idx_t'(mhc_r - CW'(1)); down_r <= 1'b0;
          ret_r <= {1'b0, S_L4}; state_r <= {1'b0, S_SU0};
        end
        {1'b0, S_L4}: begin
          res_entry_r <= CW'(e_r) + CW'(1); res_key_r <= v_r; res_status_r <= ST_OK;
          state_r <= Q_FIN;
        end
        // sift up, optionally followed by sift down
        {1'b0, S_SU0}: begin
          if (p_r == '0) state_r <= down_r ? {1'b0, S_SD0} : ret_r;
          else state_r <= {1'b0, S_SU1};
        end
        {1'b0, S_SU1}: begin a_r <= sl_rd; state_r <= {1'b0, S_SU2}; end
        {1'b0, S_SU2}: begin b_r <= sl_rd; state_r <= {1'b0, S_SU3}; end
        {1'b0, S_SU3}: begin ak_r <= ks_rd; state_r <= {1'b0, S_SU4}; end
        {1'b0, S_SU4}: begin
          if (ahead(h_r, ak_r, a_r, ks_rd, b_r)) state_r <= {1'b0, S_SU5};
          else state_r <= down_r ? {1'b0, S_SD0} : ret_r;
        end
        {1'b0, S_SU5}: begin p_r <= par; state_r <= {1'b0, S_SU0}; end
        // sift down
        {1'b0, S_SD0}: begin
          if (CW'(p_r) >= cnt_r) state_r <= ret_r;
          else state_r <= {1'b0, S_SD1};
        end
        {1'b0, S_SD1}: begin a_r <= sl_rd; state_r <= {1'b0, S_SD2}; end
        {1'b0, S_SD2}: begin
          bestk_r <= ks_rd; beste_r <= a_r; best_r <= p_r;
          state_r <= (lft < (CW+1)'(cnt_r)) ? {1'b0, S_SD3} : {1'b0, S_SDC};
        end
        {1'b0, S_SD3}: begin b_r <= sl_rd; state_r <= {1'b0, S_SD4}; end
        {1'b0, S_SD4}: begin
          if (ahead(h_r, ks_rd, b_r, bestk_r, beste_r)) begin
            bestk_r <= ks_rd; beste_r <= b_r; best_r <= lft[AW-1:0];
          end
          state_r <= (rgt < (CW+1)'(cnt_r)) ? {1'b0, S_SD5} : {1'b0, S_SDC};
        end
        {1'b0, S_SD5}: begin b_r <= sl_rd; state_r <= {1'b0, S_SD6}; end
        {1'b0, S_SD6}: begin
          if (ahead(h_r, ks_rd, b_r, bestk_r, beste_r)) begin
            bestk_r <= ks_rd; beste_r <= b_r; best_r <= rgt[AW-1:0];
          end
          state_r <= {1'b0, S_SDC};
        end
        {1'b0, S_SDC}: state_r <= (best_r == p_r) ? ret_r : {1'b0, S_SD8};
        {1'b0, S_SD8}: begin p_r <= best_r; state_r <= {1'b0, S_SD0}; end
        // step smallest: drop keys below 2 from the min heap top first
        {1'b0, S_S0}: begin
          if (mhc_r == '0) begin
            res_status_r <= ST_NONE; state_r <= Q_FIN;
          end else begin
            state_r <= {1'b0, S_S1};
          end
        end
        {1'b0, S_S1}: begin a_r <= sl_rd; state_r <= {1'b0, S_S2}; end
        {1'b0, S_S2}: begin
          if (ks_rd[KEY_W-1:1] == '0) begin
            mhc_r <= mhc_r - CW'(1); state_r <= {1'b0, S_S3};
          end else begin
            e_r <= a_r; state_r <= {1'b0, S_E0};
          end
        end
        {1'b0, S_S3}: begin b_r <= sl_rd; state_r <= {1'b0, S_S4}; end
        {1'b0, S_S4}: begin
          p_r <= '0; cnt_r <= mhc_r; ret_r <= {1'b0, S_S0};
          state_r <= {1'b0, S_SD0};
        end
        {1'b0, S_X1}: begin a_r <= sl_rd; state_r <= {1'b0, S_X2}; end
        {1'b0, S_X2}: begin
          if (ks_rd[KEY_W-1:1] == '0) begin
            res_status_r <= ST_NONE; state_r <= Q_FIN;
          end else begin
            e_r <= a_r; h_r <= 1'b0; state_r <= {1'b0, S_E0};
          end
        end
        // step the chosen entry, then repair both heaps
        {1'b0, S_E0}: state_r <= {1'b0, S_E1};
        {1'b0, S_E1}: begin ek_r <= collatz(ks_rd); state_r <= {1'b0, S_E2}; end
        {1'b0, S_E2}: begin
          p_r <= ps_rd; cnt_r <= mhc_r; down_r <= 1'b1; ret_r <= {1'b0, S_E3};
          state_r <= (CW'(ps_rd) < mhc_r) ? {1'b0, S_SU0} : {1'b0, S_E3};
        end
        {1'b0, S_E3}: begin h_r <= 1'b1; state_r <= Q_E4; end
        Q_E4: begin
          p_r <= ps_rd; cnt_r <= lc_r; down_r <= 1'b1; ret_r <= Q_E5;
          state_r <= (CW'(ps_rd) < lc_r) ? {1'b0, S_SU0} : Q_E5;
        end
        Q_E5: begin
          res_entry_r <= CW'(e_r) + CW'(1); res_key_r <= ek_r; res_status_r <= ST_OK;
          state_r <= Q_FIN;
        end
        Q_R1: begin
          res_key_r <= ks_rd; res_status_r <= ST_OK; state_r <= Q_FIN;
        end
        Q_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_entry_r  <= res_entry_r;
            out_key_r    <= res_key_r;
            out_status_r <= res_status_r;
            state_r      <= {1'b0, S_IDLE};
          end
        end
        default: state_r <= {1'b0, S_IDLE};
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_key_r, out_entry_r};
  assign out_tuser  = out_status_r;

endmodule

/* src/cdeh_ram.sv */
module cdeh_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* dv/collatz_double_ended_heap_core_tb.sv */
`timescale 1ns / 1ps

module collatz_double_ended_heap_core_tb;
  import cdeh_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [10:0] entry;
    logic [31:0] key;
    logic [1:0]  status;
  } heap_result_t;

  typedef struct {
    logic [1:0]   mode;
    logic [31:0]  value;
    logic [10:0]  req;
    bit           typed;
    heap_result_t res;
  } heap_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // model state; index 0 of the heap arrays is the min heap, 1 the max heap
  logic [31:0]  key_mem [ENTRIES];
  int unsigned  heap_slot [2][ENTRIES];
  int unsigned  heap_pos [2][ENTRIES];
  int unsigned  n_loaded;
  int unsigned  n_min;

  heap_result_t pending_results[$];
  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  n_mismatch = 0;
  int unsigned  n_cycles = 0;

  collatz_double_ended_heap_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] step_key(input logic [31:0] n);
    if (!n[0]) return n >> 1;
    if (n > ODD_LIMIT) return '0;
    return 32'd3 * n + 32'd1;
  endfunction

  function automatic bit outranks(input int mx, input int unsigned a, input int unsigned b);
    if (key_mem[a] == key_mem[b]) return a < b;
    return mx ? (key_mem[a] > key_mem[b]) : (key_mem[a] < key_mem[b]);
  endfunction

  function automatic void swap_slots(input int mx, input int unsigned i, input int unsigned j);
    int unsigned a;
    int unsigned b;
    a = heap_slot[mx][i];
    b = heap_slot[mx][j];
    heap_slot[mx][i] = b;
    heap_slot[mx][j] = a;
    heap_pos[mx][a] = j;
    heap_pos[mx][b] = i;
  endfunction

  function automatic int unsigned bubble_up(input int mx, input int unsigned p);
    int unsigned par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (!outranks(mx, heap_slot[mx][p], heap_slot[mx][par])) break;
      swap_slots(mx, p, par);
      p = par;
    end
    return p;
  endfunction

  function automatic void bubble_down(input int mx, input int unsigned p, input int unsigned cnt);
    int unsigned best;
    int unsigned l;
    while (p < cnt) begin
      best = p;
      l = 2 * p + 1;
      if (l < cnt && outranks(mx, heap_slot[mx][l], heap_slot[mx][best])) best = l;
      if (l + 1 < cnt && outranks(mx, heap_slot[mx][l + 1], heap_slot[mx][best])) best = l + 1;
      if (best == p) break;
      swap_slots(mx, p, best);
      p = best;
    end
  endfunction

  function automatic void resettle(input int mx, input int unsigned p, input int unsigned cnt);
    if (p >= cnt) return;
    bubble_down(mx, bubble_up(mx, p), cnt);
  endfunction

  function automatic void advance_entry(input int unsigned e);
    key_mem[e] = step_key(key_mem[e]);
    resettle(0, heap_pos[0][e], n_min);
    resettle(1, heap_pos[1][e], n_loaded);
  endfunction

  function automatic heap_result_t predict_heap(input logic [1:0] mode, input logic [31:0] value,
                                                input logic [10:0] req);
    heap_result_t r;
    int unsigned  e;
    int unsigned  moved;
    r = '0;
    case (mode)
      MODE_LOAD: begin
        if (n_loaded >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          e = n_loaded;
          key_mem[e] = value;
          heap_slot[1][e] = e;
          heap_pos[1][e] = e;
          // a dropped entry in the slot at the min heap end moves behind the new one
          if (n_min < n_loaded) begin
            moved = heap_slot[0][n_min];
            heap_slot[0][e] = moved;
            heap_pos[0][moved] = e;
          end
          heap_slot[0][n_min] = e;
          heap_pos[0][e] = n_min;
          n_loaded++;
          n_min++;
          void'(bubble_up(1, e));
          void'(bubble_up(0, n_min - 1));
          r.entry = 11'(e + 1);
          r.key = value;
        end
      end
      MODE_MIN: begin
        while (n_min > 0 && key_mem[heap_slot[0][0]] < 2) begin
          n_min--;
          swap_slots(0, 0, n_min);
          bubble_down(0, 0, n_min);
        end
        if (n_min == 0) begin
          r.status = ST_NONE;
        end else begin
          e = heap_slot[0][0];
          advance_entry(e);
          r.entry = 11'(e + 1);
          r.key = key_mem[e];
        end
      end
      MODE_MAX: begin
        if (n_loaded == 0 || key_mem[heap_slot[1][0]] < 2) begin
          r.status = ST_NONE;
        end else begin
          e = heap_slot[1][0];
          advance_entry(e);
          r.entry = 11'(e + 1);
          r.key = key_mem[e];
        end
      end
      default: begin
        if (req == 0 || req > n_loaded) begin
          r.status = ST_BADNO;
        end else begin
          r.entry = req;
          r.key = key_mem[req - 1];
        end
      end
    endcase
    return r;
  endfunction

  // holds tvalid high across back-to-back transactions
  task automatic push_item(input logic [1:0] mode, input logic [31:0] value,
                           input logic [10:0] req, input bit typed, input heap_result_t res);
    heap_result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, req, value};
    do @(posedge clk); while (!in_tready);
    r = predict_heap(mode, value, req);
    pending_results.push_back(typed ? res : r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom();
      1: return ODD_LIMIT + $urandom_range(3) - 1;
      2: return 32'hFFFFFFFF - $urandom_range(2);
      3: return $urandom_range(1);
      4, 5: return $urandom_range(100000);
      default: return $urandom_range(64);
    endcase
  endfunction

  task automatic random_item();
    logic [1:0]  mode;
    logic [31:0] value;
    logic [10:0] req;
    int unsigned pick;
    pick = $urandom_range(99);
    mode = pick < 35 ? MODE_LOAD : pick < 60 ? MODE_MIN : pick < 80 ? MODE_MAX : MODE_READ;
    value = mode == MODE_LOAD ? pick_key() : $urandom();
    case ($urandom_range(7))
      0: req = 11'($urandom_range(2047));
      1: req = 11'(n_loaded + 1);
      2: req = '0;
      default: req = n_loaded == 0 ? 11'd1 : 11'($urandom_range(n_loaded, 1));
    endcase
    push_item(mode, value, req, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transaction: entry %0d key %h status %0d",
                   out_tdata[10:0], out_tdata[42:11], out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[10:0] !== want.entry || out_tdata[42:11] !== want.key ||
            out_tuser !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected entry %0d key %h status %0d, got %0d %h %0d",
                     want.entry, want.key, want.status,
                     out_tdata[10:0], out_tdata[42:11], out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    heap_row_t rows[$];
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    n_loaded = 0;
    n_min = 0;
    rows = '{
      '{MODE_MIN,  32'd0,          11'd0,    1'b1, '{11'd0, 32'd0, ST_NONE}},
      '{MODE_MAX,  32'd5,          11'd0,    1'b1, '{11'd0, 32'd0, ST_NONE}},
      '{MODE_READ, 32'hFFFFFFFF,   11'd0,    1'b1, '{11'd0, 32'd0, ST_BADNO}},
      '{MODE_READ, 32'd0,          11'd1,    1'b1, '{11'd0, 32'd0, ST_BADNO}},
      '{MODE_LOAD, 32'hFFFFFFFF,   11'h7FF,  1'b1, '{11'd1, 32'hFFFFFFFF, ST_OK}},
      '{MODE_LOAD, 32'd0,          11'd0,    1'b1, '{11'd2, 32'd0, ST_OK}},
      '{MODE_LOAD, 32'd1,          11'd0,    1'b1, '{11'd3, 32'd1, ST_OK}},
      '{MODE_LOAD, 32'd1431655765, 11'd0,    1'b1, '{11'd4, 32'd1431655765, ST_OK}},
      '{MODE_LOAD, 32'd1431655764, 11'd0,    1'b1, '{11'd5, 32'd1431655764, ST_OK}},
      '{MODE_LOAD, 32'd1431655763, 11'd0,    1'b1, '{11'd6, 32'd1431655763, ST_OK}},
      // odd keys above the limit overflow to zero
      '{MODE_MAX,  32'd0,          11'd0,    1'b1, '{11'd1, 32'd0, ST_OK}},
      '{MODE_MAX,  32'd0,          11'd0,    1'b1, '{11'd4, 32'd0, ST_OK}},
      '{MODE_MIN,  32'd0,          11'd0,    1'b0, '0},
      '{MODE_MIN,  32'd0,          11'd0,    1'b0, '0},
      '{MODE_READ, 32'd0,          11'd2047, 1'b1, '{11'd0, 32'd0, ST_BADNO}},
      '{MODE_READ, 32'd7,          11'd2,    1'b1, '{11'd2, 32'd0, ST_OK}},
      // load after keys were dropped from the min heap
      '{MODE_LOAD, 32'd2,          11'd0,    1'b1, '{11'd7, 32'd2, ST_OK}},
      '{MODE_MIN,  32'd0,          11'd0,    1'b0, '0},
      '{MODE_MAX,  32'd0,          11'd0,    1'b0, '0},
      '{MODE_READ, 32'd0,          11'd7,    1'b0, '0},
      '{MODE_READ, 32'd0,          11'd8,    1'b1, '{11'd0, 32'd0, ST_BADNO}}
    };
    idle_set  = '{0, 87, 0, 35};
    stall_set = '{0, 0, 87, 35};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) push_item(rows[i].mode, rows[i].value, rows[i].req, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_set[ph];
      receiver_stall_pct = stall_set[ph];
      repeat (95) random_item();
      // hold off until the block has delivered everything in flight
      drain_results();
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cdeh_pkg.sv
src/cdeh_ram.sv
src/collatz_double_ended_heap_core.sv
dv/collatz_double_ended_heap_core_tb.sv
